>>> sv/wind_pulse_statistics_defines.svh
// Assertion macros for the wind pulse statistics block.
// Used by any module of the block that asserts; needs clk and arst_n in scope.
`ifndef WIND_PULSE_STATISTICS_DEFINES_SVH
`define WIND_PULSE_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/wps_pkg.sv
// Shared types and constants of the wind pulse statistics block.
// No dependencies; used by wps_ctrl, wps_dp and wind_pulse_statistics.
package wps_pkg;

	localparam int unsigned CNT_W     = 16;
	localparam int unsigned TOT_W     = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned STEP_W    = 5;

	localparam logic [CNT_W-1:0] MIN_RESET = 16'd60000;
	localparam logic [CNT_W-1:0] PPK_RESET = 16'd1;
	localparam logic [CNT_W-1:0] CUT_RESET = 16'd0;

	// Operation codes
	localparam logic [2:0] OP_PULSE     = 3'd0;
	localparam logic [2:0] OP_TICK      = 3'd1;
	localparam logic [2:0] OP_RESET     = 3'd2;
	localparam logic [2:0] OP_SET_OVR   = 3'd3;
	localparam logic [2:0] OP_CLEAR_OVR = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PPK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUT = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_RUN,
		ST_STORE,
		ST_DONE
	} state_t;

	// Which quotient the shared divider is working on
	typedef enum logic [1:0] {
		SEL_NOW,
		SEL_MIN,
		SEL_MAX,
		SEL_AVG
	} div_sel_t;

	typedef struct packed {
		logic     apply;
		logic     mul;
		logic     load;
		logic     step;
		logic     store;
		logic     cut_check;
		logic     out_load;
		div_sel_t sel;
	} cmd_t;

endpackage

>>> sv/wps_dp.sv
// Datapath of the wind pulse statistics block: statistics registers,
// configuration, denominator multiply, serial divider and result registers.
// Depends on wps_pkg.
module wps_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wps_pkg::cmd_t                       cmd,
	input  logic [2:0]                          operation,
	input  logic [wps_pkg::CNT_W-1:0]           override_value,
	input  logic                                cfg_we,
	input  logic [wps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wps_pkg::CNT_W-1:0]           cfg_data,
	output logic [wps_pkg::CNT_W-1:0]           now_knots,
	output logic [wps_pkg::CNT_W-1:0]           min_knots,
	output logic [wps_pkg::CNT_W-1:0]           max_knots,
	output logic [wps_pkg::CNT_W-1:0]           average_knots,
	output logic [wps_pkg::CNT_W-1:0]           above_cut_in_count
);

	logic [wps_pkg::CNT_W-1:0] ppk_q, cut_q;
	logic [wps_pkg::CNT_W-1:0] pulse_q, win_q, wnum_q, max_q, min_q, cutwin_q;
	logic [wps_pkg::TOT_W-1:0] total_q;
	logic                      ovr_q;
	logic [wps_pkg::CNT_W-1:0] tick_win;

	logic [wps_pkg::TOT_W-1:0] den_q, dvs_q, rem_q, quo_q;
	logic                      dzero_q;
	logic [wps_pkg::TOT_W-1:0] dvd_sel, dvs_sel;
	logic [wps_pkg::TOT_W:0]   rem_sh;
	logic [wps_pkg::TOT_W+1:0] diff;
	logic [wps_pkg::TOT_W-1:0] prod;
	logic [wps_pkg::CNT_W-1:0] q16;

	logic [wps_pkg::CNT_W-1:0] q_now_q, q_min_q, q_max_q, q_avg_q;
	logic [wps_pkg::CNT_W-1:0] o_now_q, o_min_q, o_max_q, o_avg_q, o_cut_q;

	// Window count that a tick latches
	assign tick_win = ovr_q ? win_q : pulse_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppk_q <= wps_pkg::PPK_RESET;
			cut_q <= wps_pkg::CUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wps_pkg::REG_PPK: ppk_q <= cfg_data;
				wps_pkg::REG_CUT: cut_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Apply the accepted word to the statistics; bump cut-in count on the speed check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q  <= '0;
			win_q    <= '0;
			total_q  <= '0;
			wnum_q   <= '0;
			max_q    <= '0;
			min_q    <= wps_pkg::MIN_RESET;
			cutwin_q <= '0;
			ovr_q    <= 1'b0;
		end else begin
			if (cmd.apply) begin
				case (operation)
					wps_pkg::OP_PULSE: begin
						pulse_q <= pulse_q + 16'd1;
					end
					wps_pkg::OP_TICK: begin
						win_q   <= tick_win;
						pulse_q <= '0;
						wnum_q  <= wnum_q + 16'd1;
						total_q <= total_q + {16'd0, tick_win};
						if (tick_win < min_q) min_q <= tick_win;
						if (tick_win > max_q) max_q <= tick_win;
					end
					wps_pkg::OP_RESET: begin
						if (!ovr_q) win_q <= '0;
						total_q  <= '0;
						wnum_q   <= '0;
						max_q    <= '0;
						cutwin_q <= '0;
						min_q    <= wps_pkg::MIN_RESET;
					end
					wps_pkg::OP_SET_OVR: begin
						ovr_q <= 1'b1;
						win_q <= override_value;
					end
					wps_pkg::OP_CLEAR_OVR: begin
						ovr_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.cut_check && (q16 >= cut_q)) begin
				cutwin_q <= cutwin_q + 16'd1;
			end
		end
	end

	// Average denominator: windows times pulses per knot
	assign prod = {16'd0, wnum_q} * {16'd0, ppk_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			den_q <= prod;
		end
	end

	// Select dividend and divisor for the current quotient
	always_comb begin
		case (cmd.sel)
			wps_pkg::SEL_NOW: begin
				dvd_sel = {16'd0, win_q};
				dvs_sel = {16'd0, ppk_q};
			end
			wps_pkg::SEL_MIN: begin
				dvd_sel = {16'd0, min_q};
				dvs_sel = {16'd0, ppk_q};
			end
			wps_pkg::SEL_MAX: begin
				dvd_sel = {16'd0, max_q};
				dvs_sel = {16'd0, ppk_q};
			end
			wps_pkg::SEL_AVG: begin
				dvd_sel = total_q + {17'd0, ppk_q[wps_pkg::CNT_W-1:1]};
				dvs_sel = den_q;
			end
			default: begin
				dvd_sel = '0;
				dvs_sel = '0;
			end
		endcase
	end

	// Restoring divider, one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[wps_pkg::TOT_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	// A zero divisor reads as a zero speed
	assign q16    = dzero_q ? '0 : quo_q[wps_pkg::CNT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q   <= '0;
			quo_q   <= dvd_sel;
			dvs_q   <= dvs_sel;
			dzero_q <= (dvs_sel == '0);
		end else if (cmd.step) begin
			if (!diff[wps_pkg::TOT_W+1]) begin
				rem_q <= diff[wps_pkg::TOT_W-1:0];
				quo_q <= {quo_q[wps_pkg::TOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[wps_pkg::TOT_W-1:0];
				quo_q <= {quo_q[wps_pkg::TOT_W-2:0], 1'b0};
			end
		end
	end

	// Hold finished quotients
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.sel)
				wps_pkg::SEL_NOW: q_now_q <= q16;
				wps_pkg::SEL_MIN: q_min_q <= q16;
				wps_pkg::SEL_MAX: q_max_q <= q16;
				wps_pkg::SEL_AVG: q_avg_q <= q16;
				default: ;
			endcase
		end
	end

	// Output register, loaded once the previous word has left
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_now_q <= q_now_q;
			o_min_q <= q_min_q;
			o_max_q <= q_max_q;
			o_avg_q <= q_avg_q;
			o_cut_q <= cutwin_q;
		end
	end

	assign now_knots          = o_now_q;
	assign min_knots          = o_min_q;
	assign max_knots          = o_max_q;
	assign average_knots      = o_avg_q;
	assign above_cut_in_count = o_cut_q;

endmodule

>>> sv/wps_ctrl.sv
// Controller of the wind pulse statistics block: sequences the update,
// multiply and four serial divisions, and owns the output handshake.
// Depends on wps_pkg and wind_pulse_statistics_defines.svh.
`include "wind_pulse_statistics_defines.svh"

module wps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    operation,
	output logic          out_valid,
	input  logic          out_ready,
	output wps_pkg::cmd_t cmd
);

	wps_pkg::state_t               state_q, state_d;
	wps_pkg::div_sel_t             sel_q, sel_d;
	logic [wps_pkg::STEP_W-1:0]    step_q, step_d;
	logic                          tick_q;
	logic                          out_valid_q, out_valid_d;
	logic                          accept;
	logic                          last_step;

	assign accept    = in_valid && in_ready;
	assign last_step = (step_q == wps_pkg::STEP_W'(wps_pkg::DIV_STEPS - 1));

	// State and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wps_pkg::ST_IDLE;
			sel_q       <= wps_pkg::SEL_NOW;
			step_q      <= '0;
			tick_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
			if (accept) tick_q <= (operation == wps_pkg::OP_TICK);
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		sel_d         = sel_q;
		step_d        = step_q;
		out_valid_d   = out_valid_q && !out_ready;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.sel       = sel_q;
		case (state_q)
			wps_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.apply = in_valid;
				if (in_valid) state_d = wps_pkg::ST_MUL;
			end
			wps_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				sel_d   = wps_pkg::SEL_NOW;
				state_d = wps_pkg::ST_LOAD;
			end
			wps_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				step_d   = '0;
				state_d  = wps_pkg::ST_RUN;
			end
			wps_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				step_d   = step_q + 1'b1;
				if (last_step) state_d = wps_pkg::ST_STORE;
			end
			wps_pkg::ST_STORE: begin
				cmd.store     = 1'b1;
				cmd.cut_check = tick_q && (sel_q == wps_pkg::SEL_NOW);
				if (sel_q == wps_pkg::SEL_AVG) begin
					state_d = wps_pkg::ST_DONE;
				end else begin
					sel_d   = wps_pkg::div_sel_t'(sel_q + 2'd1);
					state_d = wps_pkg::ST_LOAD;
				end
			end
			wps_pkg::ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = wps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wps_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`WPS_ASSERT_NEXT(a_accept_starts, accept, state_q == wps_pkg::ST_MUL, "accepted word did not start the sequence")
	`WPS_ASSERT_NOW(a_load_free, cmd.out_load, !out_valid_q || out_ready, "output register overwritten while held")
	`WPS_ASSERT_NEXT(a_step_count, state_q == wps_pkg::ST_RUN && !last_step, step_q == $past(step_q) + 1'b1 && state_q == wps_pkg::ST_RUN, "divider step count broke")
	`WPS_ASSERT_NEXT(a_avg_last, state_q == wps_pkg::ST_STORE && sel_q == wps_pkg::SEL_AVG, state_q == wps_pkg::ST_DONE, "sequence did not finish after average")

endmodule

>>> sv/wind_pulse_statistics.sv
// Top level of the wind pulse statistics block.
// Ties together wps_ctrl and wps_dp; depends on wps_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per item, carrying operation
//   (pulse, gather tick, reset statistics, set override, clear override) and
//   override_value. Output channel (out_valid/out_ready): one word per item
//   with the current, minimum, maximum and average speed in knots and the
//   count of windows at or above the cut-in.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): write
//   pulses per knot (index 0) or cut-in knots (index 1); always ready. The
//   user must write only while the block is idle; the block does not enforce it.
//   Sequence: an accepted word passes through a multiply state, then the single
//   restoring divider works out each of the four quotients in turn (load, run,
//   store), then the output load state; only then does the idle state take the
//   next word, so a new item is not accepted while one is in progress.
//   Reset: arst_n clears the statistics (minimum to 60000), the override,
//   pulses per knot to 1 and cut-in to 0; no output word is pending.
//   Stall: a held output word stays in its register; the next item is still
//   accepted and processed, and its result waits until the held word leaves.
module wind_pulse_statistics (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          operation,
	input  logic [wps_pkg::CNT_W-1:0]           override_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wps_pkg::CNT_W-1:0]           now_knots,
	output logic [wps_pkg::CNT_W-1:0]           min_knots,
	output logic [wps_pkg::CNT_W-1:0]           max_knots,
	output logic [wps_pkg::CNT_W-1:0]           average_knots,
	output logic [wps_pkg::CNT_W-1:0]           above_cut_in_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wps_pkg::CNT_W-1:0]           cfg_data
);

	wps_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	wps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	wps_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.operation          (operation),
		.override_value     (override_value),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.now_knots          (now_knots),
		.min_knots          (min_knots),
		.max_knots          (max_knots),
		.average_knots      (average_knots),
		.above_cut_in_count (above_cut_in_count)
	);

endmodule

>>> test/wind_statistics_checker.sv
// Checker for the wind pulse statistics block: predicts every result word and compares it.
// Watches the input, output and configuration channels; depends on wps_pkg.
module wind_statistics_checker
	import wps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [2:0]           operation,
	input  logic [CNT_W-1:0]     override_value,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [CNT_W-1:0]     now_knots,
	input  logic [CNT_W-1:0]     min_knots,
	input  logic [CNT_W-1:0]     max_knots,
	input  logic [CNT_W-1:0]     average_knots,
	input  logic [CNT_W-1:0]     above_cut_in_count,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   words_in_flight
);

	typedef struct packed {
		logic [CNT_W-1:0] now;
		logic [CNT_W-1:0] min;
		logic [CNT_W-1:0] max;
		logic [CNT_W-1:0] avg;
		logic [CNT_W-1:0] cut_in;
	} speeds_t;

	// Configuration copy
	logic [CNT_W-1:0] knot_pulses;
	logic [CNT_W-1:0] cut_in_limit;

	// Statistics copy
	logic [CNT_W-1:0] live_pulses;
	logic [CNT_W-1:0] window_pulses;
	logic [TOT_W-1:0] pulse_total;
	logic [CNT_W-1:0] window_index;
	logic [CNT_W-1:0] max_pulses;
	logic [CNT_W-1:0] min_pulses;
	logic [CNT_W-1:0] cut_in_hits;
	logic             override_on;

	speeds_t expected_speeds[$];

	assign words_in_flight = expected_speeds.size();

	initial mismatch_count = 0;

	function automatic logic [CNT_W-1:0] to_knots(input logic [CNT_W-1:0] count);
		if (knot_pulses == '0)
			return '0;
		return count / knot_pulses;
	endfunction

	// Apply one word to the statistics and return the speeds seen afterwards
	task automatic advance_statistics(input logic [2:0] op, input logic [CNT_W-1:0] ov,
			output speeds_t speeds);
		logic [TOT_W-1:0] rounded_total;
		logic [TOT_W-1:0] window_pulse_sum;
		case (op)
			OP_PULSE: begin
				live_pulses = live_pulses + 1'b1;
			end
			OP_TICK: begin
				if (!override_on)
					window_pulses = live_pulses;
				live_pulses = '0;
				window_index = window_index + 1'b1;
				pulse_total = pulse_total + TOT_W'(window_pulses);
				if (window_pulses < min_pulses)
					min_pulses = window_pulses;
				if (window_pulses > max_pulses)
					max_pulses = window_pulses;
				if (to_knots(window_pulses) >= cut_in_limit)
					cut_in_hits = cut_in_hits + 1'b1;
			end
			OP_RESET: begin
				// an active override keeps its window count
				if (!override_on)
					window_pulses = '0;
				pulse_total = '0;
				window_index = '0;
				max_pulses = '0;
				cut_in_hits = '0;
				min_pulses = MIN_RESET;
			end
			OP_SET_OVR: begin
				override_on = 1'b1;
				window_pulses = ov;
			end
			OP_CLEAR_OVR: begin
				override_on = 1'b0;
			end
			default: begin
			end
		endcase
		speeds.now = to_knots(window_pulses);
		speeds.min = to_knots(min_pulses);
		speeds.max = to_knots(max_pulses);
		speeds.cut_in = cut_in_hits;
		// average reads zero before the first window
		if (knot_pulses == '0 || window_index == '0) begin
			speeds.avg = '0;
		end else begin
			rounded_total = pulse_total + TOT_W'(knot_pulses >> 1);
			window_pulse_sum = TOT_W'(window_index) * TOT_W'(knot_pulses);
			speeds.avg = CNT_W'(rounded_total / window_pulse_sum);
		end
	endtask

	task automatic check_field(input string field, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// Track configuration, predict on accepted input words, compare accepted result words
	always @(posedge clk or negedge arst_n) begin
		speeds_t predicted;
		speeds_t oldest;
		if (!arst_n) begin
			knot_pulses = PPK_RESET;
			cut_in_limit = CUT_RESET;
			live_pulses = '0;
			window_pulses = '0;
			pulse_total = '0;
			window_index = '0;
			max_pulses = '0;
			min_pulses = MIN_RESET;
			cut_in_hits = '0;
			override_on = 1'b0;
			expected_speeds.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PPK: knot_pulses = cfg_data;
					REG_CUT: cut_in_limit = cfg_data;
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				advance_statistics(operation, override_value, predicted);
				expected_speeds.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (expected_speeds.size() == 0) begin
					$error("result word arrived with nothing pending");
					mismatch_count++;
				end else begin
					oldest = expected_speeds.pop_front();
					check_field("now_knots", oldest.now, now_knots);
					check_field("min_knots", oldest.min, min_knots);
					check_field("max_knots", oldest.max, max_knots);
					check_field("average_knots", oldest.avg, average_knots);
					check_field("above_cut_in_count", oldest.cut_in, above_cut_in_count);
				end
			end
		end
	end

endmodule

>>> test/testbench.sv
// Top of the wind pulse statistics testbench: clock, reset, stimulus, watchdog and verdict.
// Instantiates wind_pulse_statistics and wind_statistics_checker; depends on wps_pkg.
module testbench;
	import wps_pkg::*;

	// Operation codes the block leaves unused
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int PHASES       = 7;
	localparam int PHASE_WORDS  = 70;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 600;
	localparam int SETTLE_TICKS = 150;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           operation;
	logic [CNT_W-1:0]     override_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [CNT_W-1:0]     now_knots;
	logic [CNT_W-1:0]     min_knots;
	logic [CNT_W-1:0]     max_knots;
	logic [CNT_W-1:0]     average_knots;
	logic [CNT_W-1:0]     above_cut_in_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	int mismatch_count;
	int words_in_flight;
	int send_idle_pct = 27;
	int recv_idle_pct = 47;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	wind_pulse_statistics i_dut (.*);

	wind_statistics_checker i_checker (.*);

	always #5 clk = ~clk;

	// End the run when no channel moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Drive out_ready: random idling, or a long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one word and hold it until accepted; starts and ends at a falling edge
	task automatic send_word(input logic [2:0] op, input logic [CNT_W-1:0] ov);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		override_value = ov;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stop offering and wait for every predicted word to come back
	task automatic wait_for_results();
		in_valid = 1'b0;
		wait (words_in_flight == 0);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly windows of random pulse counts closed by a tick, with overrides and noise
	task automatic run_random_words(input int count);
		int sent;
		int pick;
		int pulses;
		logic [CNT_W-1:0] ov;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				pulses = $urandom_range(12);
				repeat (pulses) send_word(OP_PULSE, CNT_W'($urandom));
				send_word(OP_TICK, CNT_W'($urandom));
				sent += pulses + 1;
			end else if (pick < 77) begin
				case ($urandom_range(7))
					0: ov = '0;
					1: ov = '1;
					2, 3, 4: ov = CNT_W'($urandom_range(40));
					default: ov = CNT_W'($urandom);
				endcase
				send_word(OP_SET_OVR, ov);
				// pulses under an override are discarded at the tick
				pulses = $urandom_range(4);
				repeat (pulses) send_word(OP_PULSE, CNT_W'($urandom));
				send_word(OP_TICK, CNT_W'($urandom));
				sent += pulses + 2;
			end else if (pick < 85) begin
				send_word(OP_CLEAR_OVR, CNT_W'($urandom));
				sent++;
			end else if (pick < 91) begin
				send_word(OP_RESET, CNT_W'($urandom));
				sent++;
			end else if (pick < 95) begin
				send_word(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), CNT_W'($urandom));
				sent++;
			end else begin
				send_word(OP_TICK, CNT_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] ppk_setting;
		logic [CNT_W-1:0] cut_setting;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_PULSE;
		override_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PPK;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: unused codes before any window, then windows, overrides and resets
		send_word(OP_SPARE_HI, 16'hFFFF);
		send_word(OP_SPARE_LO, 16'h0000);
		send_word(OP_SPARE_LO + 3'd1, 16'hAAAA);
		repeat (3) send_word(OP_PULSE, 16'h5555);
		send_word(OP_TICK, 16'h0000);
		send_word(OP_TICK, 16'hFFFF);
		send_word(OP_SET_OVR, 16'hFFFF);
		send_word(OP_PULSE, 16'h0000);
		send_word(OP_TICK, 16'h0000);
		send_word(OP_RESET, 16'h0000);
		send_word(OP_TICK, 16'h0000);
		send_word(OP_CLEAR_OVR, 16'h0000);
		send_word(OP_PULSE, 16'h0000);
		send_word(OP_RESET, 16'h0000);
		send_word(OP_TICK, 16'h0000);
		send_word(OP_SET_OVR, 16'h0000);
		send_word(OP_TICK, 16'hFFFF);
		send_word(OP_SET_OVR, 16'hAAAA);
		send_word(OP_TICK, 16'h5555);
		send_word(OP_CLEAR_OVR, 16'hFFFF);
		wait_for_results();

		// Random phases, each under its own settings and one of three idling patterns
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin ppk_setting = 16'd1;     cut_setting = 16'd2;     end
				1: begin ppk_setting = 16'd0;     cut_setting = 16'd0;     end
				2: begin ppk_setting = 16'hFFFF;  cut_setting = 16'hFFFF;  end
				3: begin
					ppk_setting = CNT_W'($urandom_range(8, 1));
					cut_setting = CNT_W'($urandom_range(6));
				end
				4: begin ppk_setting = 16'd3;     cut_setting = 16'd1;     end
				5: begin ppk_setting = CNT_W'($urandom); cut_setting = CNT_W'($urandom); end
				default: begin ppk_setting = 16'd1; cut_setting = 16'd0; end
			endcase
			if (phase < 3) begin
				send_idle_pct = 27;
				recv_idle_pct = 47;
			end else if (phase < 5) begin
				send_idle_pct = 47;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_register(REG_PPK, ppk_setting);
			write_register(REG_CUT, cut_setting);
			// back up the output while words keep coming
			if (phase == 3)
				hold_cycles = HOLD_CYCLES;
			run_random_words(PHASE_WORDS);
			wait_for_results();
		end

		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatch_count == 0 && words_in_flight == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
